// ===== rtl/bfr_pkg.sv =====
package bfr_pkg;

	// Default sizes of the font store and the glyph height
	localparam int FONT_BYTES_DEF = 8192;
	localparam int GLYPH_ROWS_DEF = 16;

	// Field widths
	localparam int CUR_W   = 16;
	localparam int FADDR_W = 13;
	localparam int GADDR_W = 15;
	localparam int SW_W    = 13;
	localparam int GB_W    = 6;
	localparam int COLOR_W = 32;
	localparam int MASK_W  = 8;
	localparam int CHAR_W  = 8;

	// Cursor steps
	localparam logic [CUR_W-1:0] WRAP_SPAN = 16'd16;
	localparam logic [CUR_W-1:0] GLYPH_W   = 16'd8;

	// Character and operation codes
	localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
	localparam logic OP_PRINT = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Register map (index bit of paddr) and reset values
	localparam logic REG_SW = 1'b0;
	localparam logic REG_GB = 1'b1;
	localparam logic [SW_W-1:0] SW_RESET = 13'd1024;
	localparam logic [GB_W-1:0] GB_RESET = 6'd16;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [SW_W-1:0] screen_width;
		logic [GB_W-1:0] glyph_bytes;
	} bfr_cfg_t;

	// Shared saturating adder / compare request and result
	typedef struct packed {
		logic [CUR_W-1:0] a;
		logic [CUR_W-1:0] b;
		logic [SW_W-1:0]  limit;
	} bfr_alu_req_t;

	typedef struct packed {
		logic [CUR_W-1:0] sum_sat;
		logic             over;
	} bfr_alu_rsp_t;

endpackage

// ===== rtl/bfr_if.sv =====
interface bfr_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [bfr_pkg::CHAR_W-1:0]  char_code;
	logic [bfr_pkg::COLOR_W-1:0] color;
	logic [bfr_pkg::FADDR_W-1:0] font_addr;
	logic [bfr_pkg::MASK_W-1:0]  font_byte;

	modport source (output valid, opcode, char_code, color, font_addr, font_byte,
		input ready);
	modport sink (input valid, opcode, char_code, color, font_addr, font_byte,
		output ready);
endinterface

interface bfr_pix_if;
	logic                        valid;
	logic                        ready;
	logic [bfr_pkg::CUR_W-1:0]   pixel_x;
	logic [bfr_pkg::CUR_W-1:0]   pixel_y;
	logic [bfr_pkg::MASK_W-1:0]  row_mask;
	logic [bfr_pkg::COLOR_W-1:0] pixel_color;
	logic                        last_row;

	modport source (output valid, pixel_x, pixel_y, row_mask, pixel_color, last_row,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, row_mask, pixel_color, last_row,
		output ready);
endinterface

// ===== rtl/bitmap_font_text_renderer_unit.sv =====
// A printable character passes S_CHK and S_WRAP; S_ROW then reads one glyph row per cycle
//   from the font store unless the output stalls, through the read stage and the output
//   register, and S_ADV moves the cursor on.
// Newline, carriage return and font writes produce no rows and leave the sequencer in S_IDLE.
// Reset (arst_n low) clears the cursor, the sequencer and the valid flags and sets
//   screen_width to 1024 and glyph_bytes to 16; the font store holds no reset value.
module bitmap_font_text_renderer_unit #(
	parameter int FONT_BYTES = bfr_pkg::FONT_BYTES_DEF,
	parameter int GLYPH_ROWS = bfr_pkg::GLYPH_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bfr_cmd_if.sink     cmd,
	bfr_pix_if.source   pix,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bfr_pkg::*;

	localparam int FONT_AW = $clog2(FONT_BYTES);
	localparam int RW      = $clog2(GLYPH_ROWS);
	localparam logic [GADDR_W-1:0] FONT_LIM = GADDR_W'(FONT_BYTES);
	localparam logic [FADDR_W:0]   WR_LIM   = (FADDR_W + 1)'(FONT_BYTES);
	localparam logic [CUR_W-1:0]   LINE_H   = CUR_W'(GLYPH_ROWS);
	localparam logic [RW-1:0]      ROW_END  = RW'(GLYPH_ROWS - 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_WRAP = 3'd2;
	localparam logic [2:0] S_ROW  = 3'd3;
	localparam logic [2:0] S_ADV  = 3'd4;

	bfr_cfg_t     cfg;
	bfr_alu_req_t alu_req;
	bfr_alu_rsp_t alu_rsp;

	logic [2:0]         state_q;
	logic [CUR_W-1:0]   col_q;
	logic [CUR_W-1:0]   row_q;
	logic [RW-1:0]      r_q;
	logic [CHAR_W-1:0]  ch_q;
	logic [COLOR_W-1:0] color_q;
	logic               wrap_q;
	logic [GADDR_W-1:0] base_q;
	logic [GADDR_W-1:0] gaddr_q;

	// Read stage: request in flight to the font store
	logic               pend_s1;
	logic [CUR_W-1:0]   x_s1;
	logic [CUR_W-1:0]   y_s1;
	logic               oob_s1;
	logic               last_s1;
	logic [COLOR_W-1:0] color_s1;

	// Output register
	logic               out_valid_q;
	logic [CUR_W-1:0]   out_x_q;
	logic [CUR_W-1:0]   out_y_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	logic              cmd_acc;
	logic              font_we;
	logic              out_free;
	logic              advance;
	logic              issue;
	logic              row_last;
	logic [MASK_W-1:0] ram_rdata;

	bfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	bfr_ram #(
		.WIDTH (MASK_W),
		.DEPTH (FONT_BYTES)
	) u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (cmd.font_addr[FONT_AW-1:0]),
		.wdata (cmd.font_byte),
		.re    (issue),
		.raddr (gaddr_q[FONT_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Handshake and pipeline advance
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid & cmd.ready;
	assign font_we   = cmd_acc && (cmd.opcode == OP_WRITE)
		&& ({1'b0, cmd.font_addr} < WR_LIM);
	assign out_free  = !out_valid_q || pix.ready;
	assign advance   = !pend_s1 || out_free;
	assign issue     = (state_q == S_ROW) && advance;
	assign row_last  = (r_q == ROW_END);

	// Operand select for the shared adder
	always_comb begin
		alu_req.a     = row_q;
		alu_req.b     = LINE_H;
		alu_req.limit = cfg.screen_width;
		case (state_q)
			S_CHK: begin
				alu_req.a = col_q;
				alu_req.b = WRAP_SPAN;
			end
			S_ROW: begin
				alu_req.b = {{(CUR_W - RW){1'b0}}, r_q};
			end
			S_ADV: begin
				alu_req.a = col_q;
				alu_req.b = GLYPH_W;
			end
			default: ;
		endcase
	end

	// Sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			r_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc && cmd.opcode == OP_PRINT) begin
						if (cmd.char_code == CHAR_NL) begin
							row_q <= alu_rsp.sum_sat;
						end else if (cmd.char_code == CHAR_CR) begin
							col_q <= '0;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (wrap_q) begin
						col_q <= '0;
						row_q <= alu_rsp.sum_sat;
					end
					r_q     <= '0;
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (issue) begin
						r_q <= r_q + 1'b1;
						if (row_last) begin
							state_q <= S_ADV;
						end
					end
				end
				S_ADV: begin
					col_q   <= alu_rsp.sum_sat;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload, wrap flag and glyph address
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			ch_q    <= cmd.char_code;
			color_q <= cmd.color;
		end
		if (state_q == S_CHK) begin
			wrap_q <= alu_rsp.over;
			base_q <= {{(GADDR_W - CHAR_W){1'b0}}, ch_q}
				* {{(GADDR_W - GB_W){1'b0}}, cfg.glyph_bytes};
		end
		if (state_q == S_WRAP) begin
			gaddr_q <= base_q;
		end else if (issue) begin
			gaddr_q <= gaddr_q + 1'b1;
		end
	end

	// Valid flags of the read stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pend_s1 <= issue;
			end
			if (out_free) begin
				out_valid_q <= pend_s1;
			end
		end
	end

	// Row payload through the read stage into the output register
	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1     <= col_q;
			y_s1     <= alu_rsp.sum_sat;
			oob_s1   <= !(gaddr_q < FONT_LIM);
			last_s1  <= row_last;
			color_s1 <= color_q;
		end
		if (pend_s1 && out_free) begin
			out_x_q     <= x_s1;
			out_y_q     <= y_s1;
			out_mask_q  <= oob_s1 ? '0 : ram_rdata;
			out_color_q <= color_s1;
			out_last_q  <= last_s1;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_y     = out_y_q;
	assign pix.row_mask    = out_mask_q;
	assign pix.pixel_color = out_color_q;
	assign pix.last_row    = out_last_q;

	// A stalled read stage keeps its font byte
	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !out_free |=> pend_s1 && $stable(ram_rdata))
		else $error("font read data lost while output stalled");

	// Row counter stays inside the glyph
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> (32'(r_q) < GLYPH_ROWS))
		else $error("glyph row counter out of range");

	// Last row read moves on to the column advance
	a_last_adv: assert property (@(posedge clk) disable iff (!arst_n)
		issue && row_last |=> state_q == S_ADV)
		else $error("sequencer missed column advance");

endmodule

// ===== rtl/bfr_ram.sv =====
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bfr_alu.sv =====
module bfr_alu (
	input  bfr_pkg::bfr_alu_req_t req,
	output bfr_pkg::bfr_alu_rsp_t rsp
);
	import bfr_pkg::*;

	logic [CUR_W:0] sum;

	// 17-bit sum, saturated to 16 bits, and compared against the limit
	always_comb begin
		sum         = {1'b0, req.a} + {1'b0, req.b};
		rsp.sum_sat = sum[CUR_W] ? {CUR_W{1'b1}} : sum[CUR_W-1:0];
		rsp.over    = sum > {{(CUR_W + 1 - SW_W){1'b0}}, req.limit};
	end

endmodule

// ===== rtl/bfr_cfg.sv =====
module bfr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output bfr_pkg::bfr_cfg_t cfg
);
	import bfr_pkg::*;

	logic [SW_W-1:0] sw_q;
	logic [GB_W-1:0] gb_q;
	logic            wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SW_RESET;
			gb_q <= GB_RESET;
		end else if (wr) begin
			case (paddr[2])
				REG_SW: sw_q <= pwdata[SW_W-1:0];
				REG_GB: gb_q <= pwdata[GB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (paddr[2])
			REG_SW: prdata = {{(32 - SW_W){1'b0}}, sw_q};
			REG_GB: prdata = {{(32 - GB_W){1'b0}}, gb_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.screen_width = sw_q;
	assign cfg.glyph_bytes  = gb_q;

endmodule
